[rtl/core/crts_pkg.sv]
// Shared types and constants for the CAN receive timeout supervisor.
package crts_pkg;

    localparam int ENTRIES_DEF       = 96;
    localparam int UNKNOWN_DEPTH_DEF = 8;
    localparam int ID_W              = 29;
    localparam int LIMIT_W           = 16;
    localparam int TIME_W            = 32;
    localparam int IDX_W             = 7;
    localparam int MAP_W             = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FRAME = 2'd1,
        OP_CHECK = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // one classified item as queued between front and back
    typedef struct packed {
        op_t                op;
        logic               in_range;
        logic [IDX_W-1:0]   index;
        logic [ID_W-1:0]    ident;
        logic [LIMIT_W-1:0] limit;
        logic               enable;
        logic [TIME_W-1:0]  now;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UNK,
        ST_STAMP,
        ST_DONE
    } state_t;

endpackage

[rtl/core/crts_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
module crts_front
    import crts_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [ID_W-1:0]    s_entry_id,
    input  logic [LIMIT_W-1:0] s_entry_timeout,
    input  logic               s_entry_enable,
    input  logic [ID_W-1:0]    s_frame_id,
    input  logic [TIME_W-1:0]  s_now_ms,
    output logic               q_valid,
    input  logic               q_ready,
    output cmd_t               q_cmd
);

    // two-slot queue
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd_in;
    logic       push, pop;

    always_comb begin
        cmd_in.op       = op_t'(s_operation);
        cmd_in.in_range = ({25'd0, s_entry_index} < ENTRIES);
        cmd_in.index    = s_entry_index;
        cmd_in.ident    = (s_operation == OP_LOAD) ? s_entry_id : s_frame_id;
        cmd_in.limit    = s_entry_timeout;
        cmd_in.enable   = s_entry_enable;
        cmd_in.now      = s_now_ms;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an item");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

[rtl/core/crts_back.sv]
// Back end: entry table walk, unknown-id list and result register.
module crts_back
    import crts_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int UNKNOWN_DEPTH = UNKNOWN_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  cmd_t               q_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_known,
    output logic [IDX_W-1:0]   m_matched_index,
    output logic               m_unknown_first_seen,
    output logic [MAP_W-1:0]   m_map_low,
    output logic [MAP_W-1:0]   m_map_mid,
    output logic [MAP_W-1:0]   m_map_high
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = (UNKNOWN_DEPTH > 1) ? $clog2(UNKNOWN_DEPTH) : 1;
    localparam int CW = $clog2(UNKNOWN_DEPTH + 1);
    localparam logic [EW-1:0] LAST_E = EW'(ENTRIES - 1);
    localparam logic [CW-1:0] UDEPTH = CW'(UNKNOWN_DEPTH);

    // table memories
    logic [ID_W-1:0]    ident_mem [ENTRIES];
    logic [LIMIT_W-1:0] limit_mem [ENTRIES];
    logic [TIME_W-1:0]  stamp_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    // an entry never stamped reads its stamp as zero
    logic [ENTRIES-1:0] stamped_reg;
    logic [ID_W-1:0]    unk_reg [UNKNOWN_DEPTH];
    logic [CW-1:0]      ucnt_reg, ucnt_next;
    logic [UW-1:0]      unext_reg, unext_next;

    state_t        state_reg, state_next;
    cmd_t          cmd_reg;
    logic [EW-1:0] ptr_reg, ptr_next;
    logic [EW-1:0] rptr;
    logic          rd_ok_reg;          // read data below belongs to ptr_reg
    logic [ID_W-1:0]    rd_ident_reg;
    logic [LIMIT_W-1:0] rd_limit_reg;
    logic [TIME_W-1:0]  rd_stamp_reg;
    logic               rd_stamped_reg;
    logic [ENTRIES-1:0] map_reg;
    logic          hit_reg;
    logic [EW-1:0] hit_idx_reg;
    logic          seen;
    logic          res_full_reg;
    logic          take, cur_valid, cur_match, cur_late, last_e;
    logic [TIME_W-1:0] age;
    logic [3*MAP_W-1:0] map_wide;

    assign q_ready   = (state_reg == ST_IDLE) && !res_full_reg;
    assign take      = q_valid && q_ready;
    assign cur_valid = valid_reg[ptr_reg];
    assign cur_match = cur_valid && (rd_ident_reg == cmd_reg.ident);
    assign age       = cmd_reg.now - (rd_stamped_reg ? rd_stamp_reg : '0);
    assign cur_late  = cur_valid && (rd_limit_reg != '0) && ({16'd0, rd_limit_reg} < age);
    assign last_e    = (ptr_reg == LAST_E);

    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < UNKNOWN_DEPTH; i++) begin
            if (CW'(i) < ucnt_reg && unk_reg[i] == cmd_reg.ident) begin
                seen = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (q_cmd.op == OP_FRAME || q_cmd.op == OP_CHECK) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_ok_reg) begin
                    if (cmd_reg.op == OP_FRAME && cur_match) begin
                        state_next = ST_STAMP;
                    end else if (last_e) begin
                        state_next = (cmd_reg.op == OP_FRAME) ? ST_UNK : ST_DONE;
                    end
                end
            end
            ST_UNK:   state_next = ST_DONE;
            ST_STAMP: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the walk
    always_comb begin
        ptr_next = ptr_reg;
        rptr     = ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ptr_next = '0;
                rptr     = '0;
            end
            ST_SCAN: begin
                if (rd_ok_reg && !last_e) begin
                    ptr_next = ptr_reg + 1'b1;
                    rptr     = ptr_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        ucnt_next  = ucnt_reg;
        unext_next = unext_reg;
        if (state_reg == ST_UNK && !seen) begin
            unext_next = (unext_reg == UW'(UNKNOWN_DEPTH - 1)) ? '0 : unext_reg + 1'b1;
            if (ucnt_reg < UDEPTH) begin
                ucnt_next = ucnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            stamped_reg  <= '0;
            ucnt_reg     <= '0;
            unext_reg    <= '0;
            rd_ok_reg    <= 1'b0;
            res_full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ucnt_reg  <= ucnt_next;
            unext_reg <= unext_next;
            rd_ok_reg <= (state_next == ST_SCAN);
            if (state_reg == ST_DONE && cmd_reg.op == OP_LOAD && cmd_reg.in_range) begin
                valid_reg[cmd_reg.index[EW-1:0]] <= cmd_reg.enable;
            end
            if (state_reg == ST_STAMP) begin
                stamped_reg[hit_idx_reg] <= 1'b1;
            end
            if (state_reg == ST_DONE) begin
                res_full_reg <= 1'b1;
            end else if (m_ready) begin
                res_full_reg <= 1'b0;
            end
        end
    end

    // memories: one read port, one write port
    always_ff @(posedge aclk) begin
        rd_ident_reg   <= ident_mem[rptr];
        rd_limit_reg   <= limit_mem[rptr];
        rd_stamp_reg   <= stamp_mem[rptr];
        rd_stamped_reg <= stamped_reg[rptr];
        if (state_reg == ST_DONE && cmd_reg.op == OP_LOAD && cmd_reg.in_range) begin
            ident_mem[cmd_reg.index[EW-1:0]] <= cmd_reg.ident;
            limit_mem[cmd_reg.index[EW-1:0]] <= cmd_reg.limit;
        end
        if (state_reg == ST_STAMP) begin
            stamp_mem[hit_idx_reg] <= cmd_reg.now;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg  <= q_cmd;
            map_reg  <= '0;
            hit_reg  <= 1'b0;
            hit_idx_reg <= '0;
            m_unknown_first_seen <= 1'b0;
        end
        if (state_reg == ST_SCAN && rd_ok_reg) begin
            if (cmd_reg.op == OP_CHECK) begin
                map_reg[ptr_reg] <= cur_late;
            end else if (cur_match) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= ptr_reg;
            end
        end
        if (state_reg == ST_UNK) begin
            m_unknown_first_seen <= !seen;
            if (!seen) begin
                unk_reg[unext_reg] <= cmd_reg.ident;
            end
        end
        if (state_reg == ST_IDLE) begin
            ptr_reg <= ptr_next;
        end else begin
            ptr_reg <= ptr_next;
        end
    end

    assign map_wide        = (3*MAP_W)'(map_reg);
    assign m_valid         = res_full_reg;
    assign m_frame_known   = hit_reg;
    assign m_matched_index = IDX_W'(hit_idx_reg);
    assign m_map_low       = map_wide[MAP_W-1:0];
    assign m_map_mid       = map_wide[2*MAP_W-1:MAP_W];
    assign m_map_high      = map_wide[3*MAP_W-1:2*MAP_W];

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_map_low) && $stable(m_frame_known))
        else $error("result changed while waiting");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_known && m_unknown_first_seen))
        else $error("frame both known and unknown");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ucnt_reg <= UDEPTH)
        else $error("unknown count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STAMP) |-> hit_reg)
        else $error("stamp without match");

endmodule

[rtl/core/can_rx_timeout_supervisor.sv]
// Top level of the CAN receive timeout supervisor.
//  channel | direction | ports
//  s_      | in        | s_valid/s_ready, operation, entry and frame fields, now_ms
//  m_      | out       | m_valid/m_ready, frame_known .. map_high
// Load and unused items go straight to the result. A frame walks the table one entry a
// cycle through the memory read port and stops at a match; a check walks every entry.
// Reset clears the valid bits, the per-entry stamped flags, the unknown list count
// and the queue; an entry never stamped reads its stamp as zero. A two-slot queue
// accepts until both slots are full while the back end works or its result waits.
module can_rx_timeout_supervisor
    import crts_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int UNKNOWN_DEPTH = UNKNOWN_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [ID_W-1:0]    s_entry_id,
    input  logic [LIMIT_W-1:0] s_entry_timeout,
    input  logic               s_entry_enable,
    input  logic [ID_W-1:0]    s_frame_id,
    input  logic [TIME_W-1:0]  s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_known,
    output logic [IDX_W-1:0]   m_matched_index,
    output logic               m_unknown_first_seen,
    output logic [MAP_W-1:0]   m_map_low,
    output logic [MAP_W-1:0]   m_map_mid,
    output logic [MAP_W-1:0]   m_map_high
);

    logic q_valid, q_ready;
    cmd_t q_cmd;

    crts_front #(.ENTRIES(ENTRIES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operation, .s_entry_index,
        .s_entry_id, .s_entry_timeout, .s_entry_enable, .s_frame_id, .s_now_ms,
        .q_valid, .q_ready, .q_cmd
    );

    crts_back #(.ENTRIES(ENTRIES), .UNKNOWN_DEPTH(UNKNOWN_DEPTH)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .m_valid, .m_ready,
        .m_frame_known, .m_matched_index, .m_unknown_first_seen,
        .m_map_low, .m_map_mid, .m_map_high
    );

endmodule
